FILE: src/r2h_pkg.sv
// ----------------------------------------------------------------------------
// r2h_pkg : shared types and constants for the RGB to HSV converter
// Beat layouts, the fixed-point scale factors and the divider geometry.
// ----------------------------------------------------------------------------
package r2h_pkg;

    localparam int CH_W          = 8;
    localparam int HUE_FRAC_BITS = 7;
    localparam int SAT_FRAC_BITS = 16;
    localparam int HUE_W         = 16;
    localparam int SAT_W         = SAT_FRAC_BITS + 1;

    // 60 degrees and a full turn, in hue LSBs
    localparam int HUE_UNIT = 60 << HUE_FRAC_BITS;
    localparam int HUE_FULL = 6 * HUE_UNIT;

    // hue pre-multiplier: at most 5*255, i.e. (diff + 4*delta)
    localparam int X_W = $clog2(5 * 255 + 1);

    // divider geometry: both lanes run the same number of steps
    localparam int DEN_W    = CH_W;
    localparam int QUO_W    = SAT_W;
    localparam int HNUM_W   = $clog2((5 * 255) * HUE_UNIT + 1);
    localparam int SNUM_W   = CH_W + SAT_FRAC_BITS;
    localparam int NUM_W    = (HNUM_W > SNUM_W) ? HNUM_W : SNUM_W;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pix_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [CH_W-1:0]  value;
    } hsv_t;

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    // fields that ride alongside the divider
    typedef struct packed {
        logic [CH_W-1:0] value;
        logic            hue_neg;
        logic            hue_zero;
        logic            sat_zero;
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0] hue_num;
        logic [DEN_W-1:0] hue_den;
        logic [NUM_W-1:0] sat_num;
        logic [DEN_W-1:0] sat_den;
        side_t            side;
    } div_in_t;

endpackage

FILE: src/r2h_front.sv
// ----------------------------------------------------------------------------
// r2h_front : channel sort and hue numerator
// Two stages: max/min/sector/delta, then the scaled hue numerator.
// ----------------------------------------------------------------------------
module r2h_front
    import r2h_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    pix_valid,
    input  pix_t    pix_data,
    output logic    div_valid,
    output div_in_t div_data
);

    // stage 1
    logic                   s1_valid_reg;
    logic [CH_W-1:0]        s1_max_reg;
    logic [CH_W-1:0]        s1_delta_reg;
    sector_t                s1_sect_reg;
    logic signed [CH_W:0]   s1_diff_reg;

    logic [CH_W-1:0]        max_next;
    logic [CH_W-1:0]        min_next;
    sector_t                sect_next;
    logic signed [CH_W:0]   diff_next;
    logic signed [CH_W:0]   r_s;
    logic signed [CH_W:0]   g_s;
    logic signed [CH_W:0]   b_s;

    assign r_s = $signed({1'b0, pix_data.red});
    assign g_s = $signed({1'b0, pix_data.green});
    assign b_s = $signed({1'b0, pix_data.blue});

    always_comb
    begin
        // ties: red over green, green over blue
        if (pix_data.red >= pix_data.green && pix_data.red >= pix_data.blue)
        begin
            sect_next = SECT_RED;
            max_next  = pix_data.red;
            diff_next = g_s - b_s;
        end
        else if (pix_data.green >= pix_data.blue)
        begin
            sect_next = SECT_GREEN;
            max_next  = pix_data.green;
            diff_next = b_s - r_s;
        end
        else
        begin
            sect_next = SECT_BLUE;
            max_next  = pix_data.blue;
            diff_next = r_s - g_s;
        end

        min_next = pix_data.red;
        if (pix_data.green < min_next)
        begin
            min_next = pix_data.green;
        end
        if (pix_data.blue < min_next)
        begin
            min_next = pix_data.blue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_max_reg   <= max_next;
            s1_delta_reg <= max_next - min_next;
            s1_sect_reg  <= sect_next;
            s1_diff_reg  <= diff_next;
        end
    end

    // stage 2
    logic                   s2_valid_reg;
    div_in_t                s2_data_reg;

    logic signed [X_W:0]    diff_w;
    logic signed [X_W:0]    delta_w;
    logic signed [X_W:0]    x_s;
    logic [X_W-1:0]         x_next;
    logic                   neg_next;
    div_in_t                div_next;

    assign diff_w  = (X_W+1)'(s1_diff_reg);
    assign delta_w = $signed({{(X_W+1-CH_W){1'b0}}, s1_delta_reg});

    always_comb
    begin
        neg_next = 1'b0;
        unique case (s1_sect_reg)
            SECT_RED:
            begin
                neg_next = s1_diff_reg < 0;
                x_s      = neg_next ? -diff_w : diff_w;
            end
            SECT_GREEN: x_s = diff_w + (delta_w <<< 1);
            SECT_BLUE:  x_s = diff_w + (delta_w <<< 2);
            default:    x_s = '0;
        endcase
        x_next = x_s[X_W-1:0];

        div_next.hue_num        = NUM_W'(x_next) * NUM_W'(HUE_UNIT);
        div_next.hue_den        = s1_delta_reg;
        div_next.sat_num        = NUM_W'({s1_delta_reg, {SAT_FRAC_BITS{1'b0}}});
        div_next.sat_den        = s1_max_reg;
        div_next.side.value     = s1_max_reg;
        div_next.side.hue_neg   = neg_next;
        div_next.side.hue_zero  = s1_delta_reg == '0;
        div_next.side.sat_zero  = s1_max_reg == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_data_reg <= div_next;
        end
    end

    assign div_valid = s2_valid_reg;
    assign div_data  = s2_data_reg;

endmodule

FILE: src/r2h_div.sv
// ----------------------------------------------------------------------------
// r2h_div : dual-lane pipelined restoring divider
// One quotient bit per stage for hue and saturation side by side.
// ----------------------------------------------------------------------------
module r2h_div
    import r2h_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  div_in_t          in_data,
    output logic             out_valid,
    output side_t            out_side,
    output logic [QUO_W-1:0] hue_quo,
    output logic [QUO_W-1:0] sat_quo
);

    localparam int HEAD_W = NUM_W - QUO_W;

    // one long-division step: shift in the next numerator bit, try subtract
    function automatic logic [DEN_W+QUO_W-1:0] div_step(
        input logic [DEN_W-1:0] rem,
        input logic [QUO_W-1:0] low,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_o;
        trial = {rem, low[QUO_W-1]};
        diff  = trial - {1'b0, den};
        ge    = trial >= {1'b0, den};
        rem_o = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        return {rem_o, low[QUO_W-2:0], ge};
    endfunction

    logic [QUO_W-1:0] valid_reg;
    logic [DEN_W-1:0] hrem_reg [QUO_W];
    logic [QUO_W-1:0] hlow_reg [QUO_W];
    logic [DEN_W-1:0] hden_reg [QUO_W];
    logic [DEN_W-1:0] srem_reg [QUO_W];
    logic [QUO_W-1:0] slow_reg [QUO_W];
    logic [DEN_W-1:0] sden_reg [QUO_W];
    side_t            side_reg [QUO_W];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        logic                   v_in;
        logic [DEN_W-1:0]       hrem_in;
        logic [QUO_W-1:0]       hlow_in;
        logic [DEN_W-1:0]       hden_in;
        logic [DEN_W-1:0]       srem_in;
        logic [QUO_W-1:0]       slow_in;
        logic [DEN_W-1:0]       sden_in;
        side_t                  side_in;
        logic [DEN_W+QUO_W-1:0] h_next;
        logic [DEN_W+QUO_W-1:0] s_next;

        if (s == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign hrem_in = DEN_W'(in_data.hue_num[NUM_W-1 -: HEAD_W]);
            assign hlow_in = in_data.hue_num[QUO_W-1:0];
            assign hden_in = in_data.hue_den;
            assign srem_in = DEN_W'(in_data.sat_num[NUM_W-1 -: HEAD_W]);
            assign slow_in = in_data.sat_num[QUO_W-1:0];
            assign sden_in = in_data.sat_den;
            assign side_in = in_data.side;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[s-1];
            assign hrem_in = hrem_reg[s-1];
            assign hlow_in = hlow_reg[s-1];
            assign hden_in = hden_reg[s-1];
            assign srem_in = srem_reg[s-1];
            assign slow_in = slow_reg[s-1];
            assign sden_in = sden_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        assign h_next = div_step(hrem_in, hlow_in, hden_in);
        assign s_next = div_step(srem_in, slow_in, sden_in);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hrem_reg[s] <= h_next[DEN_W+QUO_W-1:QUO_W];
                hlow_reg[s] <= h_next[QUO_W-1:0];
                hden_reg[s] <= hden_in;
                srem_reg[s] <= s_next[DEN_W+QUO_W-1:QUO_W];
                slow_reg[s] <= s_next[QUO_W-1:0];
                sden_reg[s] <= sden_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];
    assign hue_quo   = hlow_reg[QUO_W-1];
    assign sat_quo   = slow_reg[QUO_W-1];

endmodule

FILE: src/rgb_to_hsv_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_core : pixel-stream RGB to HSV converter
// Throughput: one pixel per cycle while the output is not stalled; the 17-stage divider pipeline sets latency.
// A stall on the output freezes every stage at once, so nothing is dropped.
// Reset clears only the valid bits; the data path needs no reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_core
    import r2h_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pix_valid,
    output logic pix_ready,
    input  pix_t pix_data,
    output logic hsv_valid,
    input  logic hsv_ready,
    output hsv_t hsv_data
);

    // Pipeline map
    //   front  : 2 stages, max/min/sector/delta then hue numerator x*60*2^7
    //   div    : 17 stages, restoring division, one quotient bit per stage,
    //            hue = num/delta and saturation = (delta<<16)/max in parallel
    //   output : 1 stage, grey/black masking and negative hue wrap
    // The output register is the last stage; the whole pipe advances whenever
    // that register is empty or being drained this cycle.

    logic             adv;
    logic             div_in_valid;
    div_in_t          div_in_data;
    logic             div_out_valid;
    side_t            div_side;
    logic [QUO_W-1:0] hue_quo;
    logic [QUO_W-1:0] sat_quo;

    logic             hsv_valid_reg;
    hsv_t             hsv_data_reg;
    hsv_t             hsv_next;
    logic [HUE_W-1:0] hue_mag;

    assign adv       = !hsv_valid_reg || hsv_ready;
    assign pix_ready = adv;

    r2h_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .pix_valid (pix_valid),
        .pix_data  (pix_data),
        .div_valid (div_in_valid),
        .div_data  (div_in_data)
    );

    r2h_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (div_in_valid),
        .in_data   (div_in_data),
        .out_valid (div_out_valid),
        .out_side  (div_side),
        .hue_quo   (hue_quo),
        .sat_quo   (sat_quo)
    );

    // Hue quotient is at most 5*60*2^7, so it fits the hue field.
    assign hue_mag = hue_quo[HUE_W-1:0];

    always_comb
    begin
        hsv_next.value = div_side.value;

        // grey pixel: no hue
        if (div_side.hue_zero)
        begin
            hsv_next.hue = '0;
        end
        // red sector with g < b: hue truncated toward zero, then wrapped
        else if (div_side.hue_neg && hue_mag != '0)
        begin
            hsv_next.hue = HUE_W'(HUE_FULL) - hue_mag;
        end
        else
        begin
            hsv_next.hue = hue_mag;
        end

        // black pixel: saturation forced to zero
        hsv_next.saturation = div_side.sat_zero ? '0 : SAT_W'(sat_quo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsv_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            hsv_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hsv_data_reg <= hsv_next;
        end
    end

    assign hsv_valid = hsv_valid_reg;
    assign hsv_data  = hsv_data_reg;

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb : self-checking bench for the RGB to HSV pixel converter
// Pixel beats are queued by a sequencer block and played into the core by a
// clocked driver. A clocked monitor compares every HSV beat, field by field,
// against the prediction made when the pixel beat was accepted. Both sides
// idle and stall in random bursts, except in a final steady stretch.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import r2h_pkg::*;

    // no accepted beat on either side for this long means the core has hung
    localparam int WATCHDOG_LIMIT = 2000;
    // quiet cycles after the last expected beat, to catch stray extra beats
    localparam int TAIL_CYCLES    = 40;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic pix_valid = 1'b0;
    logic pix_ready;
    pix_t pix_data  = '0;
    logic hsv_valid;
    logic hsv_ready = 1'b0;
    hsv_t hsv_data;

    pix_t pixels_q[$];       // pixel beats waiting to be driven
    hsv_t hsv_expected_q[$]; // predicted HSV beats, oldest first

    int errors       = 0;
    int idle_cycles  = 0;
    int send_gap     = 0;
    int recv_stall   = 0;
    bit send_fired;
    bit steady       = 1'b0; // set for the final stretch: no idling, no stalls
    hsv_t got_hsv;
    hsv_t want_hsv;

    rgb_to_hsv_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hsv_data  (hsv_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor. Value is the largest channel, saturation is delta/max scaled
    // and floored, hue is the sector offset plus diff/delta, scaled to hue
    // LSBs and truncated toward zero. Ties go red, then green, then blue.
    // ------------------------------------------------------------------------
    function automatic hsv_t hsv_of(pix_t px);
        longint  r;
        longint  g;
        longint  b;
        longint  hi;
        longint  lo;
        longint  span;
        longint  diff;
        longint  offset;
        longint  h;
        longint  s;
        sector_t sect;
        hsv_t    res;
        r  = px.red;
        g  = px.green;
        b  = px.blue;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        span = hi - lo;
        h    = 0;
        s    = 0;
        // black: saturation stays zero
        if (hi != 0)
            s = (span << SAT_FRAC_BITS) / hi;
        // grey: hue stays zero
        if (span != 0)
        begin
            if (hi == r)
                sect = SECT_RED;
            else if (hi == g)
                sect = SECT_GREEN;
            else
                sect = SECT_BLUE;
            case (sect)
                SECT_RED:
                begin
                    diff   = g - b;
                    offset = 0;
                end
                SECT_GREEN:
                begin
                    diff   = b - r;
                    offset = 2 * span;
                end
                default:
                begin
                    diff   = r - g;
                    offset = 4 * span;
                end
            endcase
            // longint division truncates toward zero, as wanted here
            h = (longint'(HUE_UNIT) * (diff + offset)) / span;
            if (h < 0)
                h += HUE_FULL;
        end
        res.hue        = HUE_W'(h);
        res.saturation = SAT_W'(s);
        res.value      = CH_W'(hi);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Random pixel mix: plenty of fully random pixels, plus greys, ties for
    // the maximum, narrow spreads (tiny delta) and channels at the rails.
    // ------------------------------------------------------------------------
    function automatic pix_t random_pixel();
        pix_t px;
        int   hi;
        int   lo;
        int   base;
        px = pix_t'(24'($urandom()));
        case ($urandom_range(0, 9))
            5:
            begin
                px.red   = CH_W'($urandom_range(0, 255));
                px.green = px.red;
                px.blue  = px.red;
            end
            6:
            begin
                hi = $urandom_range(0, 255);
                lo = $urandom_range(0, hi);
                case ($urandom_range(0, 2))
                    0: px = pix_t'{CH_W'(hi), CH_W'(hi), CH_W'(lo)};
                    1: px = pix_t'{CH_W'(lo), CH_W'(hi), CH_W'(hi)};
                    default: px = pix_t'{CH_W'(hi), CH_W'(lo), CH_W'(hi)};
                endcase
            end
            7:
            begin
                base     = $urandom_range(0, 250);
                px.red   = CH_W'(base + $urandom_range(0, 5));
                px.green = CH_W'(base + $urandom_range(0, 5));
                px.blue  = CH_W'(base + $urandom_range(0, 5));
            end
            8:
            begin
                // rail values on a random subset of channels
                if ($urandom_range(0, 1)) px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                if ($urandom_range(0, 1)) px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                if ($urandom_range(0, 1)) px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default:
            begin
            end
        endcase
        return px;
    endfunction

    task automatic report(input string what);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // wait until every queued pixel has gone in and every HSV beat has come out;
    // checked on the falling edge so the clocked blocks have settled
    task automatic drain();
        while (pixels_q.size() != 0 || pix_valid || hsv_expected_q.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Pixel driver. The prediction is taken at the accepting edge. A new beat
    // is only loaded once the current one has gone, so valid and data hold
    // steady under backpressure. Idle bursts are drawn at random after a beat
    // is loaded and fall between beats.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_valid <= 1'b0;
            send_gap   = 0;
        end
        else
        begin
            send_fired = pix_valid && pix_ready;
            if (send_fired)
                hsv_expected_q.push_back(hsv_of(pix_data));
            if (!pix_valid || send_fired)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    pix_valid <= 1'b0;
                end
                else if (pixels_q.size() != 0)
                begin
                    pix_data  <= pixels_q.pop_front();
                    pix_valid <= 1'b1;
                    if (!steady && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 5);
                end
                else
                    pix_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // HSV monitor: checks each accepted beat against the oldest prediction
    // and throws in random stall bursts on ready.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hsv_ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (hsv_valid && hsv_ready)
            begin
                got_hsv = hsv_data;
                if (hsv_expected_q.size() == 0)
                    report($sformatf("HSV beat with nothing expected: hue %0d sat %0d val %0d",
                                     got_hsv.hue, got_hsv.saturation, got_hsv.value));
                else
                begin
                    want_hsv = hsv_expected_q.pop_front();
                    if (got_hsv.hue !== want_hsv.hue)
                        report($sformatf("hue: got %0d, want %0d",
                                         got_hsv.hue, want_hsv.hue));
                    if (got_hsv.saturation !== want_hsv.saturation)
                        report($sformatf("saturation: got %0d, want %0d",
                                         got_hsv.saturation, want_hsv.saturation));
                    if (got_hsv.value !== want_hsv.value)
                        report($sformatf("value: got %0d, want %0d",
                                         got_hsv.value, want_hsv.value));
                end
            end
            if (recv_stall != 0)
            begin
                recv_stall--;
                hsv_ready <= 1'b0;
            end
            else
            begin
                hsv_ready <= 1'b1;
                if (!steady && $urandom_range(0, 7) == 0)
                    recv_stall = $urandom_range(1, 5);
            end
        end
    end

    // watchdog: a long run of cycles with no beat accepted on either side
    always @(posedge clk)
    begin
        if (!rst_n || (pix_valid && pix_ready) || (hsv_valid && hsv_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Sequencer: directed corners, then random phases. The drain between the
    // first two random phases holds the sender off until the pipe is empty.
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        pixels_q.push_back(pix_t'{8'd0,   8'd0,   8'd0});   // black
        pixels_q.push_back(pix_t'{8'd255, 8'd255, 8'd255}); // white
        pixels_q.push_back(pix_t'{8'd128, 8'd128, 8'd128}); // mid grey
        pixels_q.push_back(pix_t'{8'd1,   8'd1,   8'd1});   // darkest grey
        pixels_q.push_back(pix_t'{8'd255, 8'd0,   8'd0});   // pure red
        pixels_q.push_back(pix_t'{8'd0,   8'd255, 8'd0});   // pure green
        pixels_q.push_back(pix_t'{8'd0,   8'd0,   8'd255}); // pure blue
        pixels_q.push_back(pix_t'{8'd255, 8'd255, 8'd0});   // red/green tie
        pixels_q.push_back(pix_t'{8'd0,   8'd255, 8'd255}); // green/blue tie
        pixels_q.push_back(pix_t'{8'd255, 8'd0,   8'd255}); // red/blue tie, wraps
        pixels_q.push_back(pix_t'{8'd255, 8'd0,   8'd1});   // red sector, wraps
        pixels_q.push_back(pix_t'{8'd255, 8'd1,   8'd0});
        pixels_q.push_back(pix_t'{8'd1,   8'd0,   8'd0});   // full sat, max of one
        pixels_q.push_back(pix_t'{8'd0,   8'd0,   8'd1});
        pixels_q.push_back(pix_t'{8'd1,   8'd0,   8'd1});
        pixels_q.push_back(pix_t'{8'd255, 8'd254, 8'd254}); // delta of one
        pixels_q.push_back(pix_t'{8'd255, 8'd255, 8'd254});
        pixels_q.push_back(pix_t'{8'd254, 8'd255, 8'd0});
        pixels_q.push_back(pix_t'{8'd0,   8'd1,   8'd255});
        pixels_q.push_back(pix_t'{8'd200, 8'd100, 8'd50});
        pixels_q.push_back(pix_t'{8'd50,  8'd200, 8'd100});
        pixels_q.push_back(pix_t'{8'd100, 8'd50,  8'd200});
        pixels_q.push_back(pix_t'{8'd255, 8'd128, 8'd0});
        pixels_q.push_back(pix_t'{8'd128, 8'd0,   8'd255});
        pixels_q.push_back(pix_t'{8'd170, 8'd85,  8'd255});
        drain();

        repeat (350) pixels_q.push_back(random_pixel());
        drain();

        repeat (250) pixels_q.push_back(random_pixel());
        while (pixels_q.size() != 0)
            @(posedge clk);

        // closing stretch at full rate on both sides
        steady = 1'b1;
        repeat (100) pixels_q.push_back(random_pixel());
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
